### rtl/core/assert_macros.svh
// Assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)
`endif
`endif

### rtl/core/rpa_pkg.sv
package rpa_pkg;
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_INCREF = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OOM     = 3'd1;
    localparam logic [2:0] ST_BADADDR = 3'd2;
    localparam logic [2:0] ST_NOTALLOC = 3'd3;
    localparam logic [2:0] ST_SAT     = 3'd4;

    localparam int ADDR_W = 56;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        addr_ok;
        logic [16:0] idx;
    } cmd_t;
endpackage

### rtl/core/rpa_front.sv
module rpa_front #(
    parameter int PG_SH = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_req_type,
    input  logic [rpa_pkg::ADDR_W-1:0] s_page_addr,
    input  logic [rpa_pkg::ADDR_W-1:0] pool_start,
    input  logic [16:0]                pool_pages,
    input  logic                       flush,
    output logic                       q_valid,
    input  logic                       q_ready,
    output rpa_pkg::cmd_t              q_cmd
);
    localparam int QD = 2;
    rpa_pkg::cmd_t q_reg [QD];
    logic [1:0] cnt_reg;
    logic rd_reg, wr_reg;
    logic [rpa_pkg::ADDR_W-1:0] off;
    logic [rpa_pkg::ADDR_W-1:0] pg;
    rpa_pkg::cmd_t c;
    logic push, pop;

    assign off = s_page_addr - pool_start;
    assign pg = off >> PG_SH;
    always_comb begin
        c.req_type = s_req_type;
        c.idx = pg[16:0];
        c.addr_ok = (s_page_addr[PG_SH-1:0] == '0) && (s_page_addr >= pool_start)
            && (pg < {{(rpa_pkg::ADDR_W-17){1'b0}}, pool_pages});
    end

    assign s_ready = (cnt_reg != 2'(QD)) && !flush;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = q_reg[rd_reg];
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_reg] <= c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop) rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

### rtl/core/rpa_back.sv
module rpa_back #(
    parameter int MAX_PAGES = 32768,
    parameter int PG_SH = 12,
    parameter int IDX_W = 15
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  rpa_pkg::cmd_t              q_cmd,
    input  logic [rpa_pkg::ADDR_W-1:0] pool_start,
    input  logic [16:0]                pool_pages,
    input  logic                       rebuild,
    output logic                       busy,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rpa_pkg::ADDR_W-1:0] m_alloc_addr,
    output logic [2:0]                 m_status,
    output logic [7:0]                 m_count_after
);
    localparam logic [1:0] S_CLR = 2'd0, S_IDLE = 2'd1, S_EXEC = 2'd2;
    logic [1:0] st_reg, st_next;
    logic [7:0] cnt_mem [MAX_PAGES];
    logic [IDX_W-1:0] stk_mem [MAX_PAGES];
    logic [7:0] cnt_rd;
    logic [IDX_W-1:0] stk_rd;
    logic [16:0] clr_reg, depth_reg, fresh_reg;
    rpa_pkg::cmd_t cmd_reg;
    logic [IDX_W-1:0] ridx;
    logic cw_en, sw_en;
    logic [IDX_W-1:0] cw_a;
    logic [7:0] cw_d;
    logic [IDX_W-1:0] alloc_idx;
    logic alloc_hit;
    logic [rpa_pkg::ADDR_W-1:0] a_next;
    logic [2:0] s_next;
    logic [7:0] k_next;
    logic dpop, dpush, fdec, start;

    assign busy = (st_reg != S_IDLE);
    assign q_ready = (st_reg == S_IDLE) && !(m_valid && !m_ready) && !rebuild;
    assign start = q_valid && q_ready;
    assign ridx = (q_cmd.req_type == rpa_pkg::REQ_ALLOC) ? IDX_W'(fresh_reg - 17'd1)
        : q_cmd.idx[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        cnt_rd <= cnt_mem[ridx];
        stk_rd <= stk_mem[IDX_W'(depth_reg - 17'd1)];
        if (cw_en) cnt_mem[cw_a] <= cw_d;
        if (sw_en) stk_mem[depth_reg[IDX_W-1:0]] <= cmd_reg.idx[IDX_W-1:0];
    end

    always_comb begin
        a_next = '0; s_next = rpa_pkg::ST_OK; k_next = '0;
        cw_en = 1'b0; cw_a = cmd_reg.idx[IDX_W-1:0]; cw_d = '0;
        sw_en = 1'b0; dpop = 1'b0; dpush = 1'b0; fdec = 1'b0;
        alloc_idx = (depth_reg != 0) ? stk_rd : IDX_W'(fresh_reg - 17'd1);
        alloc_hit = (depth_reg != 0) || (fresh_reg != 0);
        st_next = st_reg;
        unique case (st_reg)
            S_CLR: begin
                cw_en = 1'b1; cw_a = clr_reg[IDX_W-1:0];
                if (clr_reg == 17'(MAX_PAGES - 1)) st_next = S_IDLE;
            end
            S_IDLE: if (start) st_next = S_EXEC;
            S_EXEC: begin
                st_next = S_IDLE;
                priority case (cmd_reg.req_type)
                    rpa_pkg::REQ_ALLOC: begin
                        if (alloc_hit) begin
                            dpop = (depth_reg != 0); fdec = (depth_reg == 0);
                            cw_en = 1'b1; cw_a = alloc_idx; cw_d = 8'd1;
                            a_next = pool_start
                                + ({{(rpa_pkg::ADDR_W-IDX_W){1'b0}}, alloc_idx} << PG_SH);
                            k_next = 8'd1;
                        end else s_next = rpa_pkg::ST_OOM;
                    end
                    rpa_pkg::REQ_FREE, rpa_pkg::REQ_INCREF: begin
                        if (!cmd_reg.addr_ok) s_next = rpa_pkg::ST_BADADDR;
                        else if (cnt_rd == 0) s_next = rpa_pkg::ST_NOTALLOC;
                        else if (cmd_reg.req_type == rpa_pkg::REQ_FREE) begin
                            cw_en = 1'b1; cw_d = cnt_rd - 8'd1; k_next = cw_d;
                            if (cw_d == 0 && depth_reg < 17'(MAX_PAGES)) begin
                                sw_en = 1'b1; dpush = 1'b1;
                            end
                        end else if (cnt_rd == 8'd255) begin
                            s_next = rpa_pkg::ST_SAT; k_next = 8'd255;
                        end else begin
                            cw_en = 1'b1; cw_d = cnt_rd + 8'd1; k_next = cw_d;
                        end
                    end
                    default: ;
                endcase
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (start) cmd_reg <= q_cmd;
        if (st_reg == S_EXEC) begin
            m_alloc_addr <= a_next; m_status <= s_next; m_count_after <= k_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || rebuild) begin
            st_reg <= S_CLR; clr_reg <= '0; depth_reg <= '0;
            fresh_reg <= pool_pages; m_valid <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == S_CLR) clr_reg <= clr_reg + 17'd1;
            if (dpop) depth_reg <= depth_reg - 17'd1;
            if (dpush) depth_reg <= depth_reg + 17'd1;
            if (fdec) fresh_reg <= fresh_reg - 17'd1;
            if (st_reg == S_EXEC) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end
endmodule

### rtl/core/refcounted_page_allocator.sv
// channel  | dir | handshake              | payload
// s_       | in  | s_valid / s_ready      | s_req_type, s_page_addr
// m_       | out | m_valid / m_ready      | m_alloc_addr, m_status, m_count_after
// cfg_     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
// Each request: count/stack memory read, then update and result, before the next one is taken.
// After reset or any register write a clearing pass over all MAX_PAGES entries
// of the count memory runs; requests may queue in front but none is executed meanwhile.
// Requests queue two deep in front; a stalled result holds the back end.
`include "assert_macros.svh"
module refcounted_page_allocator #(
    parameter int MAX_PAGES = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_req_type,
    input  logic [rpa_pkg::ADDR_W-1:0] s_page_addr,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rpa_pkg::ADDR_W-1:0] m_alloc_addr,
    output logic [2:0]                 m_status,
    output logic [7:0]                 m_count_after,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index,
    input  logic [rpa_pkg::ADDR_W-1:0] cfg_data
);
    localparam int PG_SH = $clog2(PAGE_BYTES);
    localparam int IDX_W = $clog2(MAX_PAGES);
    localparam logic [rpa_pkg::ADDR_W-1:0] PMASK = rpa_pkg::ADDR_W'(PAGE_BYTES - 1);

    logic [rpa_pkg::ADDR_W-1:0] base_reg, top_reg, start_reg;
    logic [16:0] pages_reg;
    logic [2:0] rb_reg;
    logic cfg_wr, busy, q_valid, q_ready;
    rpa_pkg::cmd_t q_cmd;
    logic [rpa_pkg::ADDR_W-1:0] rbase, span, npg;
    logic res_oom, res_zero;

    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && cfg_ready;
    assign rbase = (base_reg + PMASK) & ~PMASK;
    assign span = top_reg - start_reg;
    assign npg = (top_reg > start_reg) ? (span >> PG_SH) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= 56'd2147483648; top_reg <= 56'd2281701376; rb_reg <= 3'd1;
        end else begin
            if (cfg_wr && !cfg_index) base_reg <= cfg_data;
            if (cfg_wr && cfg_index) top_reg <= cfg_data;
            rb_reg <= cfg_wr ? 3'd1 : {rb_reg[1:0], 1'b0};
        end
        start_reg <= rbase;
        pages_reg <= (npg > rpa_pkg::ADDR_W'(MAX_PAGES)) ? 17'(MAX_PAGES) : npg[16:0];
    end

    rpa_front #(.PG_SH(PG_SH)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_req_type, .s_page_addr,
        .pool_start(start_reg), .pool_pages(pages_reg), .flush(rb_reg != 0),
        .q_valid, .q_ready, .q_cmd
    );

    rpa_back #(.MAX_PAGES(MAX_PAGES), .PG_SH(PG_SH), .IDX_W(IDX_W)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .pool_start(start_reg), .pool_pages(pages_reg), .rebuild(rb_reg[2]), .busy,
        .m_valid, .m_ready, .m_alloc_addr, .m_status, .m_count_after
    );

    assign res_oom = m_valid && (m_status == rpa_pkg::ST_OOM);
    assign res_zero = (m_alloc_addr == 0) && (m_count_after == 0);

    `ASSERT_NEVER(a_status_range, aclk, aresetn, m_valid && (m_status > rpa_pkg::ST_SAT))
    `ASSERT_IMPL(a_oom_zero, aclk, aresetn, res_oom |-> res_zero)
    `ASSERT_NEVER(a_no_take_busy, aclk, aresetn, q_valid && q_ready && busy)
endmodule
